/* src/swqf_pkg.sv */
// shared constants, types and the step table of the quadratic window fit
package swqf_pkg;

  localparam int WINDOW_MAX  = 32;
  localparam int SLOT_BITS   = $clog2(WINDOW_MAX);
  localparam int COUNT_BITS  = 6;
  localparam int SAMPLE_BITS = 12;
  localparam int WORD_BITS   = 160;
  localparam int LIMB_BITS   = 32;
  localparam int LIMBS       = WORD_BITS / LIMB_BITS;
  localparam int COEF_BITS   = 48;
  localparam int ERR_BITS    = 48;
  localparam int FRAC_SHIFT  = 16;
  localparam int ERR_SHIFT   = 24;
  localparam int FIT_MIN_POINTS = 4;

  typedef logic [WORD_BITS-1:0] word_t;

  // register file entries
  localparam logic [4:0] R_SX    = 5'd0;
  localparam logic [4:0] R_SY    = 5'd1;
  localparam logic [4:0] R_SXX   = 5'd2;
  localparam logic [4:0] R_SXY   = 5'd3;
  localparam logic [4:0] R_SXXX  = 5'd4;
  localparam logic [4:0] R_SXXY  = 5'd5;
  localparam logic [4:0] R_SXXXX = 5'd6;
  localparam logic [4:0] R_X2    = 5'd7;
  localparam logic [4:0] R_XY    = 5'd8;
  localparam logic [4:0] R_X3    = 5'd9;
  localparam logic [4:0] R_X2Y   = 5'd10;
  localparam logic [4:0] R_X4    = 5'd11;
  localparam logic [4:0] R_P     = 5'd12;
  localparam logic [4:0] R_Q     = 5'd13;
  localparam logic [4:0] R_R     = 5'd14;
  localparam logic [4:0] R_U     = 5'd15;
  localparam logic [4:0] R_V     = 5'd16;
  localparam logic [4:0] R_D     = 5'd17;
  localparam logic [4:0] R_AN    = 5'd18;
  localparam logic [4:0] R_BN    = 5'd19;
  localparam logic [4:0] R_CN    = 5'd20;
  localparam logic [4:0] R_KD    = 5'd21;
  localparam logic [4:0] R_CA    = 5'd22;
  localparam logic [4:0] R_CB    = 5'd23;
  localparam logic [4:0] R_CC    = 5'd24;
  localparam logic [4:0] R_RES   = 5'd25;
  localparam logic [4:0] R_ACC   = 5'd26;
  localparam logic [4:0] R_LAST_SUM = R_SXXXX;

  // operand codes with the top bit set select a value outside the register file
  localparam logic [5:0] SRC_XR   = 6'h20;
  localparam logic [5:0] SRC_YR   = 6'h21;
  localparam logic [5:0] SRC_Y16  = 6'h22;
  localparam logic [5:0] SRC_ONE  = 6'h23;
  localparam logic [5:0] SRC_KR   = 6'h24;
  localparam logic [5:0] SRC_ZERO = 6'h25;

  // write-back modes
  localparam logic [1:0] M_LOAD = 2'd0;
  localparam logic [1:0] M_ADD  = 2'd1;
  localparam logic [1:0] M_SUB  = 2'd2;
  localparam logic [1:0] M_ACC  = 2'd3;

  // program entry points
  localparam int PC_BITS = 6;
  localparam logic [PC_BITS-1:0] PC_TERMS = 6'd0;
  localparam logic [PC_BITS-1:0] PC_FIT   = 6'd12;
  localparam logic [PC_BITS-1:0] PC_RINIT = 6'd32;
  localparam logic [PC_BITS-1:0] PC_RES   = 6'd33;

  typedef struct packed {
    logic [5:0] src_a;
    logic [5:0] src_b;
    logic [4:0] dst;
    logic [1:0] mode;
    logic       last;
  } ustep_t;

  function automatic logic [5:0] rf(input logic [4:0] r);
    return {1'b0, r};
  endfunction

  function automatic ustep_t mk(input logic [5:0] a, input logic [5:0] b,
                                input logic [4:0] d, input logic [1:0] m,
                                input logic l);
    ustep_t s;
    s.src_a = a;
    s.src_b = b;
    s.dst   = d;
    s.mode  = m;
    s.last  = l;
    return s;
  endfunction

  // step table: dst = base +/- a * b
  function automatic ustep_t ustep(input logic [PC_BITS-1:0] pc);
    ustep_t s;
    s = mk(SRC_ZERO, SRC_ZERO, R_ACC, M_LOAD, 1'b1);
    case (pc)
      // power terms of one point, added to or removed from the sums
      6'd0:  s = mk(SRC_XR, SRC_XR, R_X2, M_LOAD, 1'b0);
      6'd1:  s = mk(SRC_XR, SRC_YR, R_XY, M_LOAD, 1'b0);
      6'd2:  s = mk(rf(R_X2), SRC_XR, R_X3, M_LOAD, 1'b0);
      6'd3:  s = mk(rf(R_X2), SRC_YR, R_X2Y, M_LOAD, 1'b0);
      6'd4:  s = mk(rf(R_X2), rf(R_X2), R_X4, M_LOAD, 1'b0);
      6'd5:  s = mk(SRC_XR, SRC_ONE, R_SX, M_ACC, 1'b0);
      6'd6:  s = mk(SRC_YR, SRC_ONE, R_SY, M_ACC, 1'b0);
      6'd7:  s = mk(rf(R_X2), SRC_ONE, R_SXX, M_ACC, 1'b0);
      6'd8:  s = mk(rf(R_XY), SRC_ONE, R_SXY, M_ACC, 1'b0);
      6'd9:  s = mk(rf(R_X3), SRC_ONE, R_SXXX, M_ACC, 1'b0);
      6'd10: s = mk(rf(R_X2Y), SRC_ONE, R_SXXY, M_ACC, 1'b0);
      6'd11: s = mk(rf(R_X4), SRC_ONE, R_SXXXX, M_ACC, 1'b1);
      // normal equation terms
      6'd12: s = mk(SRC_KR, rf(R_SXX), R_P, M_LOAD, 1'b0);
      6'd13: s = mk(rf(R_SX), rf(R_SX), R_P, M_SUB, 1'b0);
      6'd14: s = mk(SRC_KR, rf(R_SXY), R_Q, M_LOAD, 1'b0);
      6'd15: s = mk(rf(R_SX), rf(R_SY), R_Q, M_SUB, 1'b0);
      6'd16: s = mk(SRC_KR, rf(R_SXXX), R_R, M_LOAD, 1'b0);
      6'd17: s = mk(rf(R_SX), rf(R_SXX), R_R, M_SUB, 1'b0);
      6'd18: s = mk(SRC_KR, rf(R_SXXY), R_U, M_LOAD, 1'b0);
      6'd19: s = mk(rf(R_SXX), rf(R_SY), R_U, M_SUB, 1'b0);
      6'd20: s = mk(SRC_KR, rf(R_SXXXX), R_V, M_LOAD, 1'b0);
      6'd21: s = mk(rf(R_SXX), rf(R_SXX), R_V, M_SUB, 1'b0);
      6'd22: s = mk(rf(R_P), rf(R_V), R_D, M_LOAD, 1'b0);
      6'd23: s = mk(rf(R_R), rf(R_R), R_D, M_SUB, 1'b0);
      6'd24: s = mk(rf(R_U), rf(R_P), R_AN, M_LOAD, 1'b0);
      6'd25: s = mk(rf(R_Q), rf(R_R), R_AN, M_SUB, 1'b0);
      6'd26: s = mk(rf(R_Q), rf(R_V), R_BN, M_LOAD, 1'b0);
      6'd27: s = mk(rf(R_U), rf(R_R), R_BN, M_SUB, 1'b0);
      6'd28: s = mk(rf(R_SY), rf(R_D), R_CN, M_LOAD, 1'b0);
      6'd29: s = mk(rf(R_BN), rf(R_SX), R_CN, M_SUB, 1'b0);
      6'd30: s = mk(rf(R_AN), rf(R_SXX), R_CN, M_SUB, 1'b0);
      6'd31: s = mk(SRC_KR, rf(R_D), R_KD, M_LOAD, 1'b1);
      // residual accumulator init
      6'd32: s = mk(SRC_ZERO, SRC_ONE, R_ACC, M_LOAD, 1'b1);
      // residual of one point
      6'd33: s = mk(SRC_XR, SRC_XR, R_X2, M_LOAD, 1'b0);
      6'd34: s = mk(rf(R_CA), rf(R_X2), R_RES, M_LOAD, 1'b0);
      6'd35: s = mk(rf(R_CB), SRC_XR, R_RES, M_ADD, 1'b0);
      6'd36: s = mk(rf(R_CC), SRC_ONE, R_RES, M_ADD, 1'b0);
      6'd37: s = mk(SRC_Y16, SRC_ONE, R_RES, M_SUB, 1'b0);
      6'd38: s = mk(rf(R_RES), rf(R_RES), R_ACC, M_ADD, 1'b1);
      default: s = mk(SRC_ZERO, SRC_ZERO, R_ACC, M_LOAD, 1'b1);
    endcase
    return s;
  endfunction

  // magnitude of a two's complement word
  function automatic word_t mag(input word_t v);
    return v[WORD_BITS-1] ? (~v + WORD_BITS'(1)) : v;
  endfunction

  // number of limbs up to the highest nonzero one, at least one
  function automatic logic [2:0] limb_cnt(input word_t v);
    logic [2:0] n;
    n = 3'd1;
    for (int k = 1; k < LIMBS; k++) begin
      if (|v[k*LIMB_BITS +: LIMB_BITS]) n = 3'(k + 1);
    end
    return n;
  endfunction

endpackage

/* src/sliding_window_quadratic_fit.sv */
// sliding window quadratic least-squares fit, sequenced over a register file memory
//
//   channel    | direction | handshake                     | payload
//   -----------+-----------+-------------------------------+---------------------------------
//   input      | in        | in_valid_i / in_ready_o       | op_i, x_value_i, y_value_i
//   result     | out       | out_valid_o / out_ready_i     | fit_valid_o, coef_*_o,
//              |           |                               | fit_error_o, points_held_o
//   window cfg | in        | window_size_we_i              | window_size_i
//
// one item at a time; an add item takes longer the more points are held, up to a full
// window of 32 points; the time is set by the shared 32x32 limb multiplier (one step
// per limb pair up to the highest nonzero limbs), three restoring divisions and the
// residual pass over the stored points
// after reset a clearing pass zeroes the power sums before the first item
// the result register holds an item while the next one is accepted; a finished item
// waits in its last step until the result register is free
module sliding_window_quadratic_fit (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic window_size_we_i,
  input  logic [swqf_pkg::COUNT_BITS-1:0] window_size_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic op_i,
  input  logic signed [swqf_pkg::SAMPLE_BITS-1:0] x_value_i,
  input  logic signed [swqf_pkg::SAMPLE_BITS-1:0] y_value_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic fit_valid_o,
  output logic signed [swqf_pkg::COEF_BITS-1:0] coef_a_o,
  output logic signed [swqf_pkg::COEF_BITS-1:0] coef_b_o,
  output logic signed [swqf_pkg::COEF_BITS-1:0] coef_c_o,
  output logic [swqf_pkg::ERR_BITS-1:0] fit_error_o,
  output logic [swqf_pkg::COUNT_BITS-1:0] points_held_o
);

  localparam int WB = swqf_pkg::WORD_BITS;
  localparam int SB = swqf_pkg::SAMPLE_BITS;
  localparam int CB = swqf_pkg::COUNT_BITS;
  localparam int KB = swqf_pkg::COEF_BITS;
  localparam int EB = swqf_pkg::ERR_BITS;
  localparam int LB = swqf_pkg::LIMB_BITS;

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_CHK    = 5'd2;
  localparam logic [4:0] S_EVRD   = 5'd3;
  localparam logic [4:0] S_EVCAP  = 5'd4;
  localparam logic [4:0] S_EVEND  = 5'd5;
  localparam logic [4:0] S_INS    = 5'd6;
  localparam logic [4:0] S_INSEND = 5'd7;
  localparam logic [4:0] S_FITCHK = 5'd8;
  localparam logic [4:0] S_FITEND = 5'd9;
  localparam logic [4:0] S_RA     = 5'd10;
  localparam logic [4:0] S_RB     = 5'd11;
  localparam logic [4:0] S_RC     = 5'd12;
  localparam logic [4:0] S_MUL    = 5'd13;
  localparam logic [4:0] S_WB     = 5'd14;
  localparam logic [4:0] S_DNUM   = 5'd15;
  localparam logic [4:0] S_DDEN   = 5'd16;
  localparam logic [4:0] S_DCAP   = 5'd17;
  localparam logic [4:0] S_DIT    = 5'd18;
  localparam logic [4:0] S_DRND   = 5'd19;
  localparam logic [4:0] S_DSAT   = 5'd20;
  localparam logic [4:0] S_RLOOP  = 5'd21;
  localparam logic [4:0] S_RCAP   = 5'd22;
  localparam logic [4:0] S_ERD    = 5'd23;
  localparam logic [4:0] S_ECAP   = 5'd24;
  localparam logic [4:0] S_DONE   = 5'd25;

  localparam logic [1:0] DIV_A = 2'd0;
  localparam logic [1:0] DIV_B = 2'd1;
  localparam logic [1:0] DIV_C = 2'd2;

  localparam logic [CB-1:0] WIN_MAX = CB'(swqf_pkg::WINDOW_MAX);
  localparam logic [CB-1:0] WIN_MIN = CB'(swqf_pkg::FIT_MIN_POINTS);
  localparam logic [7:0]    DIV_LAST = 8'(WB - 1);
  localparam swqf_pkg::word_t COEF_LIM = WB'(1) << (KB - 1);
  localparam swqf_pkg::word_t ERR_HALF = WB'(1) << (swqf_pkg::ERR_SHIFT - 1);
  localparam logic [KB-1:0] COEF_MAXV = {1'b0, {(KB-1){1'b1}}};
  localparam logic [KB-1:0] COEF_MINV = {1'b1, {(KB-1){1'b0}}};
  localparam logic [EB-1:0] ERR_MAXV  = {EB{1'b1}};

  // control state
  logic [4:0] state_q, ret_q;
  logic [swqf_pkg::PC_BITS-1:0] pc_q;
  logic remove_q, item_q, zero_q, vld_q;
  logic [2:0] clr_q;
  logic [CB-1:0] count_q, win_q, jres_q;
  logic [swqf_pkg::SLOT_BITS-1:0] oldest_q;
  logic [2:0] na_q, nb_q, ia_q, jb_q;
  logic [7:0] dcnt_q;
  logic [1:0] didx_q;
  logic out_valid_q;

  // payload registers
  logic signed [SB-1:0] x_q, y_q, xr_q, yr_q;
  swqf_pkg::word_t ma_q, mb_q, prod_q, dnum_q, dden_q;
  logic [WB:0] drem_q;
  logic psign_q, dsign_q;
  logic [KB-1:0] ca_q, cb_q, cc_q;
  logic [EB-1:0] err_q;
  logic fit_valid_q;
  logic [KB-1:0] oa_q, ob_q, oc_q;
  logic [EB-1:0] oe_q;
  logic [CB-1:0] oh_q;

  // memories
  swqf_pkg::word_t rf_mem [32];
  swqf_pkg::word_t rf_rdata_q;
  logic [2*SB-1:0] ring_mem [swqf_pkg::WINDOW_MAX];
  logic [2*SB-1:0] ring_rdata_q;

  swqf_pkg::ustep_t step;
  logic [4:0] rf_raddr, rf_waddr, div_num, div_den, div_dst;
  logic rf_we;
  swqf_pkg::word_t rf_wdata;
  logic [swqf_pkg::SLOT_BITS-1:0] ring_raddr, ring_waddr;
  logic ring_we;
  logic [CB-1:0] lim;
  logic [5:0] cap_src;
  swqf_pkg::word_t cap_val, cap_mag, wb_base, wb_res;
  logic wb_sub;
  logic [LB-1:0] limb_a, limb_b;
  logic [2*LB-1:0] pp;
  logic [3:0] pk;
  logic [WB:0] rem_n;
  logic rem_ge;
  logic [KB-1:0] sat_val;
  swqf_pkg::word_t err_t;
  logic accept;

  assign step   = swqf_pkg::ustep(pc_q);
  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // effective window, clamped
  always_comb begin
    if (win_q < WIN_MIN) lim = WIN_MIN;
    else if (win_q > WIN_MAX) lim = WIN_MAX;
    else lim = win_q;
  end

  // division operand and target entries
  always_comb begin
    case (didx_q)
      DIV_A: begin
        div_num = swqf_pkg::R_AN; div_den = swqf_pkg::R_D; div_dst = swqf_pkg::R_CA;
      end
      DIV_B: begin
        div_num = swqf_pkg::R_BN; div_den = swqf_pkg::R_D; div_dst = swqf_pkg::R_CB;
      end
      default: begin
        div_num = swqf_pkg::R_CN; div_den = swqf_pkg::R_KD; div_dst = swqf_pkg::R_CC;
      end
    endcase
  end

  // operand fetch: register file data or a held value
  always_comb begin
    cap_src = (state_q == S_RB) ? step.src_a : step.src_b;
    if (cap_src[5]) begin
      case (cap_src)
        swqf_pkg::SRC_XR:  cap_val = WB'(xr_q);
        swqf_pkg::SRC_YR:  cap_val = WB'(yr_q);
        swqf_pkg::SRC_Y16: cap_val = WB'(yr_q) << swqf_pkg::FRAC_SHIFT;
        swqf_pkg::SRC_ONE: cap_val = WB'(1);
        swqf_pkg::SRC_KR:  cap_val = WB'(count_q);
        default:           cap_val = '0;
      endcase
    end else begin
      cap_val = rf_rdata_q;
    end
    cap_mag = swqf_pkg::mag(cap_val);
  end

  // limb product and its place in the word
  always_comb begin
    limb_a = ma_q[{ia_q, 5'b0} +: LB];
    limb_b = mb_q[{jb_q, 5'b0} +: LB];
    pp     = limb_a * limb_b;
    pk     = {1'b0, ia_q} + {1'b0, jb_q};
  end

  // write-back: base plus or minus the product, one adder with carry in
  always_comb begin
    wb_base = (step.mode == swqf_pkg::M_LOAD) ? '0 : rf_rdata_q;
    wb_sub  = psign_q ^ ((step.mode == swqf_pkg::M_SUB) ||
                         ((step.mode == swqf_pkg::M_ACC) && remove_q));
    wb_res  = wb_base + (wb_sub ? ~prod_q : prod_q) + WB'(wb_sub);
  end

  // one restoring division step
  always_comb begin
    rem_n  = {drem_q[WB-1:0], dnum_q[WB-1]};
    rem_ge = (rem_n >= {1'b0, dden_q});
  end

  // saturation of a rounded quotient
  always_comb begin
    if (dsign_q) sat_val = (dnum_q > COEF_LIM) ? COEF_MINV : (~dnum_q[KB-1:0] + KB'(1));
    else         sat_val = (dnum_q >= COEF_LIM) ? COEF_MAXV : dnum_q[KB-1:0];
    err_t = rf_rdata_q + ERR_HALF;
  end

  // register file port control
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = step.dst;
    rf_wdata = wb_res;
    case (state_q)
      S_RA:    rf_raddr = step.src_a[4:0];
      S_RB:    rf_raddr = step.src_b[4:0];
      S_DNUM:  rf_raddr = div_num;
      S_DDEN:  rf_raddr = div_den;
      S_ERD:   rf_raddr = swqf_pkg::R_ACC;
      default: rf_raddr = step.dst;
    endcase
    case (state_q)
      S_CLR: begin
        rf_we = 1'b1; rf_waddr = {2'b0, clr_q}; rf_wdata = '0;
      end
      S_WB: rf_we = 1'b1;
      S_DSAT: begin
        rf_we = 1'b1; rf_waddr = div_dst; rf_wdata = WB'(signed'(sat_val));
      end
      default: rf_we = 1'b0;
    endcase
  end

  // point ring port control
  assign ring_raddr = (state_q == S_RLOOP) ? (oldest_q + jres_q[swqf_pkg::SLOT_BITS-1:0])
                                           : oldest_q;
  assign ring_waddr = oldest_q + count_q[swqf_pkg::SLOT_BITS-1:0];
  assign ring_we    = (state_q == S_INS);

  // register file memory
  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
    rf_rdata_q <= rf_mem[rf_raddr];
  end

  // point ring memory
  always_ff @(posedge clk_i) begin
    if (ring_we) ring_mem[ring_waddr] <= {x_q, y_q};
    ring_rdata_q <= ring_mem[ring_raddr];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ret_q <= S_IDLE;
      pc_q <= '0;
      remove_q <= 1'b0;
      item_q <= 1'b0;
      zero_q <= 1'b0;
      vld_q <= 1'b0;
      clr_q <= '0;
      count_q <= '0;
      win_q <= WIN_MAX;
      jres_q <= '0;
      oldest_q <= '0;
      na_q <= 3'd1;
      nb_q <= 3'd1;
      ia_q <= '0;
      jb_q <= '0;
      dcnt_q <= '0;
      didx_q <= DIV_A;
      out_valid_q <= 1'b0;
    end else begin
      if (window_size_we_i) win_q <= window_size_i;
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) out_valid_q <= 1'b0;
      case (state_q)
        // zero the power sums
        S_CLR: begin
          if (clr_q == swqf_pkg::R_LAST_SUM[2:0]) begin
            clr_q <= '0;
            count_q <= '0;
            oldest_q <= '0;
            vld_q <= 1'b0;
            state_q <= item_q ? S_DONE : S_IDLE;
          end else begin
            clr_q <= clr_q + 3'd1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item_q <= 1'b1;
            x_q <= x_value_i;
            y_q <= y_value_i;
            clr_q <= '0;
            state_q <= op_i ? S_CLR : S_CHK;
          end
        end
        // drop oldest points while the window is full
        S_CHK: state_q <= (count_q >= lim) ? S_EVRD : S_INS;
        S_EVRD: state_q <= S_EVCAP;
        S_EVCAP: begin
          xr_q <= ring_rdata_q[2*SB-1:SB];
          yr_q <= ring_rdata_q[SB-1:0];
          remove_q <= 1'b1;
          pc_q <= swqf_pkg::PC_TERMS;
          ret_q <= S_EVEND;
          state_q <= S_RA;
        end
        S_EVEND: begin
          oldest_q <= oldest_q + 1'b1;
          count_q <= count_q - 1'b1;
          state_q <= S_CHK;
        end
        // store and add the new point
        S_INS: begin
          xr_q <= x_q;
          yr_q <= y_q;
          remove_q <= 1'b0;
          pc_q <= swqf_pkg::PC_TERMS;
          ret_q <= S_INSEND;
          state_q <= S_RA;
        end
        S_INSEND: begin
          count_q <= count_q + 1'b1;
          state_q <= S_FITCHK;
        end
        S_FITCHK: begin
          if (count_q >= WIN_MIN) begin
            pc_q <= swqf_pkg::PC_FIT;
            ret_q <= S_FITEND;
            state_q <= S_RA;
          end else begin
            vld_q <= 1'b0;
            state_q <= S_DONE;
          end
        end
        // k*D is zero exactly when the determinant is
        S_FITEND: begin
          if (zero_q) begin
            vld_q <= 1'b0;
            state_q <= S_DONE;
          end else begin
            didx_q <= DIV_A;
            state_q <= S_DNUM;
          end
        end
        // one step: fetch a, b and base, multiply by limbs, write back
        S_RA: state_q <= S_RB;
        S_RB: begin
          ma_q <= cap_mag;
          na_q <= swqf_pkg::limb_cnt(cap_mag);
          psign_q <= cap_val[WB-1];
          state_q <= S_RC;
        end
        S_RC: begin
          mb_q <= cap_mag;
          nb_q <= swqf_pkg::limb_cnt(cap_mag);
          psign_q <= psign_q ^ cap_val[WB-1];
          prod_q <= '0;
          ia_q <= '0;
          jb_q <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          prod_q <= prod_q + (WB'(pp) << {pk, 5'b0});
          if (jb_q == nb_q - 3'd1) begin
            jb_q <= '0;
            if (ia_q == na_q - 3'd1) state_q <= S_WB;
            else ia_q <= ia_q + 3'd1;
          end else begin
            jb_q <= jb_q + 3'd1;
          end
        end
        S_WB: begin
          zero_q <= (wb_res == '0);
          if (step.last) begin
            state_q <= ret_q;
          end else begin
            pc_q <= pc_q + 1'b1;
            state_q <= S_RA;
          end
        end
        // rounded, saturated division of a scaled numerator
        S_DNUM: state_q <= S_DDEN;
        S_DDEN: begin
          dnum_q <= swqf_pkg::mag(rf_rdata_q) << swqf_pkg::FRAC_SHIFT;
          dsign_q <= rf_rdata_q[WB-1];
          state_q <= S_DCAP;
        end
        S_DCAP: begin
          dden_q <= swqf_pkg::mag(rf_rdata_q);
          dsign_q <= dsign_q ^ rf_rdata_q[WB-1];
          drem_q <= '0;
          dcnt_q <= '0;
          state_q <= S_DIT;
        end
        S_DIT: begin
          drem_q <= rem_ge ? (rem_n - {1'b0, dden_q}) : rem_n;
          dnum_q <= {dnum_q[WB-2:0], rem_ge};
          dcnt_q <= dcnt_q + 8'd1;
          if (dcnt_q == DIV_LAST) state_q <= S_DRND;
        end
        S_DRND: begin
          if ({drem_q, 1'b0} >= {2'b0, dden_q}) dnum_q <= dnum_q + WB'(1);
          state_q <= S_DSAT;
        end
        S_DSAT: begin
          case (didx_q)
            DIV_A:   ca_q <= sat_val;
            DIV_B:   cb_q <= sat_val;
            default: cc_q <= sat_val;
          endcase
          if (didx_q == DIV_C) begin
            jres_q <= '0;
            pc_q <= swqf_pkg::PC_RINIT;
            ret_q <= S_RLOOP;
            state_q <= S_RA;
          end else begin
            didx_q <= didx_q + 2'd1;
            state_q <= S_DNUM;
          end
        end
        // residual pass over the held points
        S_RLOOP: state_q <= (jres_q == count_q) ? S_ERD : S_RCAP;
        S_RCAP: begin
          xr_q <= ring_rdata_q[2*SB-1:SB];
          yr_q <= ring_rdata_q[SB-1:0];
          jres_q <= jres_q + 1'b1;
          pc_q <= swqf_pkg::PC_RES;
          ret_q <= S_RLOOP;
          state_q <= S_RA;
        end
        S_ERD: state_q <= S_ECAP;
        S_ECAP: begin
          err_q <= (|err_t[WB-1:swqf_pkg::ERR_SHIFT+EB]) ? ERR_MAXV
                   : err_t[swqf_pkg::ERR_SHIFT +: EB];
          vld_q <= 1'b1;
          state_q <= S_DONE;
        end
        // hand the item to the result register
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            item_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && (!out_valid_q || out_ready_i)) begin
      fit_valid_q <= vld_q;
      oa_q <= vld_q ? ca_q : '0;
      ob_q <= vld_q ? cb_q : '0;
      oc_q <= vld_q ? cc_q : '0;
      oe_q <= vld_q ? err_q : ERR_MAXV;
      oh_q <= count_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign fit_valid_o   = fit_valid_q;
  assign coef_a_o      = oa_q;
  assign coef_b_o      = ob_q;
  assign coef_c_o      = oc_q;
  assign fit_error_o   = oe_q;
  assign points_held_o = oh_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= WIN_MAX) else $error("point count beyond window capacity");
  a_valid_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fit_valid_o) |-> (points_held_o >= WIN_MIN))
    else $error("valid fit with too few points");
  a_invalid_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !fit_valid_o) |->
    (coef_a_o == '0 && coef_b_o == '0 && coef_c_o == '0 && fit_error_o == ERR_MAXV))
    else $error("invalid fit with nonzero fields");
  a_limb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (ia_q < na_q && jb_q < nb_q))
    else $error("limb index out of range");
`endif

endmodule

/* bench/sliding_window_quadratic_fit_test.sv */
// self-checking testbench for the sliding window quadratic fit block
`timescale 1ns / 100ps

module sliding_window_quadratic_fit_test;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;
  localparam logic [47:0] ERR_MAX = 48'hFFFF_FFFF_FFFF;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic        valid;
    logic [47:0] a;
    logic [47:0] b;
    logic [47:0] c;
    logic [47:0] err;
    logic [5:0]  pts;
  } fit_t;

  typedef struct {
    logic        op;
    logic [11:0] x;
    logic [11:0] y;
    bit          typed;
    fit_t        res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic window_size_we_i = 1'b0;
  logic [swqf_pkg::COUNT_BITS-1:0] window_size_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic op_i = 1'b0;
  logic signed [swqf_pkg::SAMPLE_BITS-1:0] x_value_i = '0;
  logic signed [swqf_pkg::SAMPLE_BITS-1:0] y_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic fit_valid_o;
  logic signed [swqf_pkg::COEF_BITS-1:0] coef_a_o, coef_b_o, coef_c_o;
  logic [swqf_pkg::ERR_BITS-1:0] fit_error_o;
  logic [swqf_pkg::COUNT_BITS-1:0] points_held_o;

  // typed expectation travels with the item being offered
  logic item_typed = 1'b0;
  fit_t item_fit = '0;

  sliding_window_quadratic_fit u_dut (
    .clk_i, .rst_ni, .window_size_we_i, .window_size_i,
    .in_valid_i, .in_ready_o, .op_i, .x_value_i, .y_value_i,
    .out_valid_o, .out_ready_i, .fit_valid_o, .coef_a_o, .coef_b_o, .coef_c_o,
    .fit_error_o, .points_held_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // model state of the window
  logic signed [11:0] win_x [swqf_pkg::WINDOW_MAX];
  logic signed [11:0] win_y [swqf_pkg::WINDOW_MAX];
  int unsigned win_head, win_cnt;
  logic [5:0] win_size_reg = 6'd32;
  wide_t s_x, s_y, s_xx, s_xy, s_xxx, s_xxy, s_xxxx;

  fit_t fit_expect_q [$];
  int unsigned errors = 0;
  int unsigned items_sent = 0, results_seen = 0, fits_valid = 0, clears_sent = 0;
  bit calm = 1'b0;
  bit hold_done = 1'b0;

  // add or remove one point from the power sums
  task automatic sums_update(input logic signed [11:0] x, input logic signed [11:0] y,
                             input bit remove);
    wide_t wx, wy, x2;
    wx = x;
    wy = y;
    x2 = wx * wx;
    if (remove) begin
      s_x -= wx; s_y -= wy; s_xx -= x2; s_xy -= wx * wy;
      s_xxx -= x2 * wx; s_xxy -= x2 * wy; s_xxxx -= x2 * x2;
    end else begin
      s_x += wx; s_y += wy; s_xx += x2; s_xy += wx * wy;
      s_xxx += x2 * wx; s_xxy += x2 * wy; s_xxxx += x2 * x2;
    end
  endtask

  function automatic wide_t round_div(input wide_t n, input wide_t d);
    logic [255:0] an, ad, q, r;
    an = n[255] ? -n : n;
    ad = d[255] ? -d : d;
    q = an / ad;
    r = an % ad;
    if (r + r >= ad) q = q + 1;
    return (n[255] != d[255]) ? -wide_t'(q) : wide_t'(q);
  endfunction

  function automatic wide_t sat48(input wide_t v);
    wide_t hi, lo;
    hi = (wide_t'(1) <<< 47) - 1;
    lo = -(wide_t'(1) <<< 47);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // apply one item to the window and work out the fit that follows
  task automatic fit_predict(input logic op, input logic signed [11:0] x,
                             input logic signed [11:0] y, output fit_t f);
    int unsigned lim, slot;
    wide_t k, p, q, r, u, v, det, an, bn, cn, ca, cb, cc, wx, res;
    logic [255:0] acc;
    lim = win_size_reg;
    if (lim < swqf_pkg::FIT_MIN_POINTS) lim = swqf_pkg::FIT_MIN_POINTS;
    if (lim > swqf_pkg::WINDOW_MAX) lim = swqf_pkg::WINDOW_MAX;
    if (op == OP_CLEAR) begin
      win_head = 0; win_cnt = 0;
      s_x = 0; s_y = 0; s_xx = 0; s_xy = 0; s_xxx = 0; s_xxy = 0; s_xxxx = 0;
    end else begin
      while (win_cnt >= lim) begin
        sums_update(win_x[win_head], win_y[win_head], 1'b1);
        win_head = (win_head + 1) % swqf_pkg::WINDOW_MAX;
        win_cnt--;
      end
      slot = (win_head + win_cnt) % swqf_pkg::WINDOW_MAX;
      win_x[slot] = x;
      win_y[slot] = y;
      win_cnt++;
      sums_update(x, y, 1'b0);
    end
    f = '0;
    f.err = ERR_MAX;
    f.pts = 6'(win_cnt);
    if (win_cnt >= swqf_pkg::FIT_MIN_POINTS) begin
      k = wide_t'(win_cnt);
      p = k * s_xx - s_x * s_x;
      q = k * s_xy - s_x * s_y;
      r = k * s_xxx - s_x * s_xx;
      u = k * s_xxy - s_xx * s_y;
      v = k * s_xxxx - s_xx * s_xx;
      det = p * v - r * r;
      if (det != 0) begin
        an = u * p - q * r;
        bn = q * v - u * r;
        cn = s_y * det - bn * s_x - an * s_xx;
        ca = sat48(round_div(an <<< 16, det));
        cb = sat48(round_div(bn <<< 16, det));
        cc = sat48(round_div(cn <<< 16, k * det));
        acc = '0;
        for (int j = 0; j < win_cnt; j++) begin
          slot = (win_head + j) % swqf_pkg::WINDOW_MAX;
          wx = win_x[slot];
          res = ca * wx * wx + cb * wx + cc - (wide_t'(win_y[slot]) <<< 16);
          acc = acc + (res * res);
        end
        acc = (acc + (256'd1 << 23)) >> 24;
        f.valid = 1'b1;
        f.a = ca[47:0];
        f.b = cb[47:0];
        f.c = cc[47:0];
        f.err = (acc > 256'(ERR_MAX)) ? ERR_MAX : acc[47:0];
      end
    end
  endtask

  task automatic field_check(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // sample both channels away from the driving edge
  always @(negedge clk_i) begin
    fit_t f, want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      fit_predict(op_i, x_value_i, y_value_i, f);
      fit_expect_q.push_back(item_typed ? item_fit : f);
      items_sent++;
      if (op_i == OP_CLEAR) clears_sent++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (fit_expect_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual points %0d", $time,
                 points_held_o);
        errors++;
      end else begin
        want = fit_expect_q.pop_front();
        if (fit_valid_o) fits_valid++;
        field_check("fit_valid", 48'(want.valid), 48'(fit_valid_o));
        field_check("coef_a", want.a, coef_a_o);
        field_check("coef_b", want.b, coef_b_o);
        field_check("coef_c", want.c, coef_c_o);
        field_check("fit_error", want.err, fit_error_o);
        field_check("points_held", 48'(want.pts), 48'(points_held_o));
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // result side: random stalls plus one long hold-off to back the block up
  initial begin
    int unsigned g;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && results_seen >= 30) begin
        out_ready_i <= 1'b0;
        repeat (6000) @(posedge clk_i);
        hold_done = 1'b1;
      end
      g = pick_gap();
      if (g != 0) begin
        out_ready_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic item_put(input logic op, input logic [11:0] x, input logic [11:0] y,
                          input bit typed, input fit_t f);
    int unsigned g;
    g = pick_gap();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    x_value_i <= x;
    y_value_i <= y;
    item_typed <= typed;
    item_fit <= f;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  // window register writes happen only with the block drained
  task automatic window_write(input logic [5:0] v);
    in_valid_i <= 1'b0;
    wait (fit_expect_q.size() == 0);
    repeat (4) @(posedge clk_i);
    window_size_we_i <= 1'b1;
    window_size_i <= v;
    @(posedge clk_i);
    window_size_we_i <= 1'b0;
    win_size_reg = v;
  endtask

  function automatic fit_t idle_fit(input int unsigned pts);
    fit_t f;
    f = '0;
    f.err = ERR_MAX;
    f.pts = 6'(pts);
    return f;
  endfunction

  row_t rows [$];

  task automatic row_add(input logic op, input int x, input int y, input bit typed,
                         input int unsigned pts);
    row_t r;
    r.op = op;
    r.x = 12'(x);
    r.y = 12'(y);
    r.typed = typed;
    r.res = idle_fit(pts);
    rows.push_back(r);
  endtask

  // one random phase: mostly points on a small-integer parabola, some noise, rare clears
  task automatic random_phase(input int unsigned n);
    int ka, kb, kc, x, y;
    int unsigned pick;
    ka = $urandom_range(0, 6) - 3;
    kb = $urandom_range(0, 40) - 20;
    kc = $urandom_range(0, 400) - 200;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        item_put(OP_CLEAR, 12'($urandom), 12'($urandom), 1'b0, '0);
      end else if (pick < 70) begin
        x = $urandom_range(0, 60) - 30;
        y = ka * x * x + kb * x + kc + (($urandom_range(0, 9) == 0) ?
            $urandom_range(0, 6) - 3 : 0);
        if (y > 2047) y = 2047;
        if (y < -2048) y = -2048;
        item_put(OP_ADD, 12'(x), 12'(y), 1'b0, '0);
      end else begin
        item_put(OP_ADD, 12'($urandom), 12'($urandom), 1'b0, '0);
      end
    end
  endtask

  initial begin
    logic [5:0] win_plan [8] = '{6'd4, 6'd0, 6'd63, 6'd6, 6'd32, 6'd5, 6'd1, 6'd17};
    win_head = 0; win_cnt = 0;
    s_x = 0; s_y = 0; s_xx = 0; s_xy = 0; s_xxx = 0; s_xxy = 0; s_xxxx = 0;

    // directed rows, default window of 32
    row_add(OP_CLEAR, 0, 0, 1'b1, 0);
    row_add(OP_ADD, 0, 0, 1'b1, 1);
    row_add(OP_ADD, 0, 5, 1'b1, 2);
    row_add(OP_ADD, 0, -7, 1'b1, 3);
    row_add(OP_ADD, 0, 9, 1'b1, 4);     // one distinct abscissa: singular
    row_add(OP_ADD, 1, 1, 1'b1, 5);     // two distinct abscissas: still singular
    row_add(OP_ADD, -2048, 2047, 1'b0, 0);
    row_add(OP_ADD, 2047, -2048, 1'b0, 0);
    row_add(OP_ADD, -1, -1, 1'b0, 0);
    row_add(OP_ADD, 2047, 2047, 1'b0, 0);
    row_add(OP_ADD, -2048, -2048, 1'b0, 0);
    row_add(OP_CLEAR, 0, 0, 1'b1, 0);
    row_add(OP_ADD, 2047, -2048, 1'b1, 1);
    row_add(OP_ADD, 2046, 2047, 1'b1, 2);
    row_add(OP_ADD, 2045, -2048, 1'b1, 3);
    row_add(OP_ADD, 2044, 2047, 1'b0, 0);   // near-collinear x, huge coefficients
    row_add(OP_ADD, -2048, 0, 1'b0, 0);
    row_add(OP_ADD, 1, 2, 1'b0, 0);
    row_add(OP_ADD, 2, 5, 1'b0, 0);
    row_add(OP_CLEAR, 0, 0, 1'b1, 0);
    row_add(OP_ADD, -1, 1, 1'b1, 1);
    row_add(OP_ADD, 0, 0, 1'b1, 2);
    row_add(OP_ADD, 1, 1, 1'b1, 3);
    row_add(OP_ADD, 2, 4, 1'b0, 0);         // exact parabola, zero residual

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) item_put(rows[i].op, rows[i].x, rows[i].y, rows[i].typed, rows[i].res);

    // random phases over window settings; 32 then 5 shrinks a full window
    foreach (win_plan[i]) begin
      window_write(win_plan[i]);
      calm = (i % 3 == 2);
      random_phase((win_plan[i] == 6'd32) ? 40 : 46);
    end
    in_valid_i <= 1'b0;

    wait (fit_expect_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("covered %0d items (%0d clears), %0d results, %0d valid fits",
             items_sent, clears_sent, results_seen, fits_valid);
    $display("window settings 0, 1, 4, 5, 6, 17, 32, 63 incl. shrink of a full window");
    if (errors == 0 && fit_expect_q.size() == 0) begin
      $display("sliding_window_quadratic_fit_test: PASS");
    end else begin
      $display("sliding_window_quadratic_fit_test: FAIL");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #40_000_000;
    $display("timeout with %0d results outstanding", fit_expect_q.size());
    $display("sliding_window_quadratic_fit_test: FAIL");
    $finish;
  end

endmodule
